/* rtl/nbp_pkg.sv */
// shared constants and types for the n-body potential block
package nbp_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int SQRT_STEPS    = 34;
   localparam int DIV_STEPS     = 64;

   typedef struct packed {
      logic [31:0] pos_z;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
      logic [31:0] mass;
   } particle_type;

   typedef struct packed {
      logic        done;
      logic        coincident;
      logic [63:0] term;
   } pair_res_type;

endpackage

/* rtl/nbp_pair_unit.sv */
// one pair term: floor(m_i*m_j / floor(sqrt(|r_i - r_j|^2))), bit-serial sqrt and divide
module nbp_pair_unit
   import nbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  particle_type pi,
   input  particle_type pj,
   output pair_res_type res
);

   typedef enum logic [2:0] {P_IDLE, P_SUM, P_CHECK, P_SQRT, P_DIV, P_DONE} pstate_type;

   pstate_type   state_ff, state_in;
   logic [63:0]  sqx_ff, sqy_ff, sqz_ff, prod_ff;
   logic [65:0]  s_ff;
   logic [67:0]  rad_ff;
   logic [37:0]  srem_ff;
   logic [33:0]  root_ff;
   logic [34:0]  drem_ff;
   logic [63:0]  quo_ff;
   logic [6:0]   step_ff;
   logic         coin_ff;

   logic [32:0]  dx_w, dy_w, dz_w;
   logic [31:0]  ax, ay, az;
   logic [37:0]  srem_sh, strial;
   logic [34:0]  drem_sh;

   always_comb begin
      dx_w = {pi.pos_x[31], pi.pos_x} - {pj.pos_x[31], pj.pos_x};
      dy_w = {pi.pos_y[31], pi.pos_y} - {pj.pos_y[31], pj.pos_y};
      dz_w = {pi.pos_z[31], pi.pos_z} - {pj.pos_z[31], pj.pos_z};
      ax = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
      ay = dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
      az = dz_w[32] ? 32'(-dz_w) : dz_w[31:0];
      srem_sh = {srem_ff[35:0], rad_ff[67:66]};
      strial  = {2'b00, root_ff, 2'b01};
      drem_sh = {drem_ff[33:0], quo_ff[63]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         P_IDLE:  if (start) state_in = P_SUM;
         P_SUM:   state_in = P_CHECK;
         P_CHECK: state_in = (s_ff == '0) ? P_DONE : P_SQRT;
         P_SQRT:  if (step_ff == 7'd0) state_in = P_DIV;
         P_DIV:   if (step_ff == 7'd0) state_in = P_DONE;
         P_DONE:  state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         P_IDLE: begin
            sqx_ff  <= 64'(ax) * 64'(ax);
            sqy_ff  <= 64'(ay) * 64'(ay);
            sqz_ff  <= 64'(az) * 64'(az);
            prod_ff <= 64'(pi.mass) * 64'(pj.mass);
         end
         P_SUM: begin
            s_ff <= 66'(sqx_ff) + 66'(sqy_ff) + 66'(sqz_ff);
         end
         P_CHECK: begin
            coin_ff <= (s_ff == '0);
            quo_ff  <= '0;
            rad_ff  <= {2'b00, s_ff};
            srem_ff <= '0;
            root_ff <= '0;
            step_ff <= 7'(SQRT_STEPS - 1);
         end
         P_SQRT: begin
            rad_ff <= {rad_ff[65:0], 2'b00};
            if (srem_sh >= strial) begin
               srem_ff <= srem_sh - strial;
               root_ff <= {root_ff[32:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               root_ff <= {root_ff[32:0], 1'b0};
            end
            if (step_ff == 7'd0) begin
               quo_ff  <= prod_ff;
               drem_ff <= '0;
               step_ff <= 7'(DIV_STEPS - 1);
            end else begin
               step_ff <= step_ff - 7'd1;
            end
         end
         P_DIV: begin
            // restoring division, one quotient bit per cycle
            if (drem_sh >= {1'b0, root_ff}) begin
               drem_ff <= drem_sh - {1'b0, root_ff};
               quo_ff  <= {quo_ff[62:0], 1'b1};
            end else begin
               drem_ff <= drem_sh;
               quo_ff  <= {quo_ff[62:0], 1'b0};
            end
            step_ff <= step_ff - 7'd1;
         end
         P_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign res.done       = (state_ff == P_DONE);
   assign res.coincident = coin_ff;
   assign res.term       = quo_ff;

endmodule

/* rtl/nbody_potential_direct_sum.sv */
// top level of the direct-sum n-body potential block
// Particles are loaded one per cycle into a 64-entry memory; a transfer with tlast
// starts the run and one result per loaded particle follows in load order. Each
// pair term goes through a bit-serial square root and a bit-serial divider in the
// pair unit, which a coincident pair skips; a waiting result is held by rsp_tready.
// Items are not accepted while a run is in progress.
module nbody_potential_direct_sum
   import nbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // particle_mass, pos_x, pos_y, pos_z
   input  logic         req_tlast,  // last_particle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // potential, particle_index, zero fill
   output logic         rsp_tlast,  // last_result
   output logic [2:0]   rsp_tuser   // overflow_flag, coincident_flag, dropped_flag
);

   typedef enum logic [2:0] {S_LOAD, S_FETCH_I, S_HOLD_I, S_NEXT_J, S_START, S_BUSY,
                             S_EMIT} state_type;

   localparam logic [63:0] SUM_CAP = 64'h8000_0000_0000_0000;

   particle_type            mem [MAX_PARTICLES];
   particle_type            rd_ff, pi_ff;
   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff, j_ff;
   logic [IDX_W-1:0]        i_ff, rd_addr;
   logic                    drop_ff, ovf_ff, coin_ff;
   logic [63:0]             sum_ff, room;
   logic                    out_valid_ff;
   logic [71:0]             out_data_ff;
   logic                    out_last_ff;
   logic [2:0]              out_user_ff;
   logic                    in_xfer, full, pair_start, last_i;
   pair_res_type            pres;

   assign req_tready = (state_ff == S_LOAD);
   assign in_xfer    = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(MAX_PARTICLES));
   assign rd_addr    = (state_ff == S_FETCH_I) ? i_ff : j_ff[IDX_W-1:0];
   assign pair_start = (state_ff == S_START);
   assign room       = SUM_CAP - sum_ff;
   assign last_i     = ((CNT_W'(i_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (in_xfer && !full) begin
         mem[count_ff[IDX_W-1:0]] <= particle_type'(req_tdata);
      end
      rd_ff <= mem[rd_addr];
   end

   nbp_pair_unit u_pair (
      .clock (clock),
      .reset (reset),
      .start (pair_start),
      .pi    (pi_ff),
      .pj    (rd_ff),
      .res   (pres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         // in S_EMIT the output register is handled below
         if (rsp_tready && state_ff != S_EMIT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (in_xfer) begin
                  if (full) drop_ff <= 1'b1;
                  else count_ff <= count_ff + CNT_W'(1);
                  if (req_tlast) begin
                     i_ff     <= '0;
                     state_ff <= S_FETCH_I;
                  end
               end
            end
            S_FETCH_I: state_ff <= S_HOLD_I;
            S_HOLD_I: begin
               pi_ff    <= rd_ff;
               j_ff     <= '0;
               sum_ff   <= '0;
               ovf_ff   <= 1'b0;
               coin_ff  <= 1'b0;
               state_ff <= S_NEXT_J;
            end
            S_NEXT_J: begin
               if (j_ff == count_ff) state_ff <= S_EMIT;
               else if (j_ff == CNT_W'(i_ff)) j_ff <= j_ff + CNT_W'(1);
               else state_ff <= S_START;
            end
            S_START: state_ff <= S_BUSY;
            S_BUSY: begin
               if (pres.done) begin
                  if (pres.coincident) begin
                     coin_ff <= 1'b1;
                  end else if (pres.term > room) begin
                     sum_ff <= SUM_CAP;
                     ovf_ff <= 1'b1;
                  end else begin
                     sum_ff <= sum_ff + pres.term;
                  end
                  j_ff     <= j_ff + CNT_W'(1);
                  state_ff <= S_NEXT_J;
               end
            end
            S_EMIT: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {2'b00, 6'(i_ff), 64'd0 - sum_ff};
                  out_last_ff  <= last_i;
                  out_user_ff  <= {drop_ff, coin_ff, ovf_ff};
                  if (last_i) begin
                     count_ff <= '0;
                     drop_ff  <= 1'b0;
                     state_ff <= S_LOAD;
                  end else begin
                     i_ff     <= i_ff + IDX_W'(1);
                     state_ff <= S_FETCH_I;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule
